// ===== src/scba_pkg.sv =====
// Shared types, constants and table functions of the size-class block allocator.
// Used by every module of the allocator; depends on nothing else.
package scba_pkg;

   localparam int NUM_PAGES = 64;
   localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int SCAN_W = PAGE_W + 1;
   localparam int IDX_W = 9;
   localparam int ID_W = PAGE_W + IDX_W;
   localparam int MAX_BLOCKS_PER_PAGE = 340;
   localparam int CLASS_COUNT = 9;
   localparam int CLASS_W = 4;
   localparam int USED_W = 9;
   localparam int PAGE_SHIFT = 12;
   localparam int BLOCK_DATA_OFS = 16;
   localparam int MAX_CLASS_BYTES = 2048;
   localparam int DIV_STEPS = 12;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;

   localparam logic [31:0] POOL_BASE_RESET = 32'h0010_0000;
   localparam logic [6:0] PAGES_EN_RESET = 7'd64;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NULL      = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_NO_PAGE   = 3'd3,
      ST_BAD_FREE  = 3'd4
   } status_type;

   typedef enum logic {
      REG_POOL_BASE = 1'b0,
      REG_PAGES_EN  = 1'b1
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_POP, S_SCAN, S_CARVE, S_FCLS, S_FDIV,
      S_FCHK, S_FRD, S_WRD, S_WSTEP, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      LRD_HEAD, LRD_FREE, LRD_CUR
   } link_sel_type;

   // Reference to a block: valid flag and block id {page, index}.
   typedef struct packed {
      logic            valid;
      logic [ID_W-1:0] id;
   } ref_type;

   typedef struct packed {
      logic    free;
      ref_type next;
   } link_type;

   typedef struct packed {
      logic [CLASS_W-1:0] cls;
      logic [USED_W-1:0]  used;
   } page_info_type;

   typedef struct packed {
      logic         load;
      logic         set_early;
      logic         pop;
      logic         scan_start;
      logic         scan_next;
      logic         carve_start;
      logic         carve_step;
      logic         set_nopage;
      logic         set_bad;
      logic         div_start;
      logic         div_step;
      logic         free_push;
      logic         walk_step;
      logic         out_load;
      link_sel_type link_sel;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic early;
      logic head_valid;
      logic scan_hit;
      logic scan_end;
      logic carve_last;
      logic div_last;
      logic geom_ok;
      logic state_ok;
      logic release_needed;
      logic walk_last;
      logic out_free;
   } stat_type;

   // Blocks per page: (4096 - 12) / (4 + class bytes).
   function automatic logic [IDX_W-1:0] blocks_in_page(input logic [CLASS_W-1:0] c);
      logic [IDX_W-1:0] n;
      case (c)
         4'd0:    n = 9'd340;
         4'd1:    n = 9'd204;
         4'd2:    n = 9'd113;
         4'd3:    n = 9'd60;
         4'd4:    n = 9'd30;
         4'd5:    n = 9'd15;
         4'd6:    n = 9'd7;
         4'd7:    n = 9'd3;
         4'd8:    n = 9'd1;
         default: n = 9'd1;
      endcase
      return n;
   endfunction

   // Distance between neighbouring blocks: header plus class bytes.
   function automatic logic [11:0] class_stride(input logic [CLASS_W-1:0] c);
      return 12'd4 + (12'd8 << c);
   endfunction

endpackage

// ===== src/scba_csr.sv =====
// Configuration registers of the allocator behind a simple APB-style port.
// Depends on scba_pkg.
module scba_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic [31:0]                    pool_base,
   output logic [6:0]                     pages_en
);
   import scba_pkg::*;

   logic [31:0]   pool_base_ff, pool_base_in;
   logic [6:0]    pages_en_ff, pages_en_in;
   reg_index_type sel;
   logic          wr;

   assign sel = reg_index_type'(paddr[2]);
   assign wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      pool_base_in = pool_base_ff;
      pages_en_in = pages_en_ff;
      if (wr) begin
         case (sel)
            REG_POOL_BASE: pool_base_in = pwdata;
            REG_PAGES_EN:  pages_en_in = pwdata[6:0];
            default:       pool_base_in = pool_base_ff;
         endcase
      end
      case (sel)
         REG_POOL_BASE: prdata = pool_base_ff;
         REG_PAGES_EN:  prdata = {25'd0, pages_en_ff};
         default:       prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RESET;
         pages_en_ff <= PAGES_EN_RESET;
      end else begin
         pool_base_ff <= pool_base_in;
         pages_en_ff <= pages_en_in;
      end
   end

   assign pool_base = pool_base_ff;
   assign pages_en = pages_en_ff;

endmodule

// ===== src/scba_ctrl.sv =====
// Sequencing state machine of the allocator: issues datapath commands.
// Depends on scba_pkg.
module scba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  scba_pkg::stat_type stat,
   output scba_pkg::cmd_type  cmd
);
   import scba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.link_sel = LRD_HEAD;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.link_sel = LRD_HEAD;
            if (stat.early) begin
               cmd.set_early = 1'b1;
               state_in = S_OUT;
            end else if (stat.is_alloc) begin
               if (stat.head_valid) begin
                  state_in = S_POP;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in = S_SCAN;
               end
            end else begin
               state_in = S_FCLS;
            end
         end
         S_POP: begin
            cmd.pop = 1'b1;
            state_in = S_OUT;
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               cmd.carve_start = 1'b1;
               state_in = S_CARVE;
            end else if (stat.scan_end) begin
               cmd.set_nopage = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_CARVE: begin
            cmd.carve_step = 1'b1;
            if (stat.carve_last) begin
               state_in = S_DECODE;
            end
         end
         S_FCLS: begin
            cmd.div_start = 1'b1;
            state_in = S_FDIV;
         end
         S_FDIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            cmd.link_sel = LRD_FREE;
            if (stat.geom_ok) begin
               state_in = S_FRD;
            end else begin
               cmd.set_bad = 1'b1;
               state_in = S_OUT;
            end
         end
         S_FRD: begin
            if (stat.state_ok) begin
               cmd.free_push = 1'b1;
               state_in = stat.release_needed ? S_WRD : S_OUT;
            end else begin
               cmd.set_bad = 1'b1;
               state_in = S_OUT;
            end
         end
         S_WRD: begin
            cmd.link_sel = LRD_CUR;
            state_in = S_WSTEP;
         end
         S_WSTEP: begin
            cmd.walk_step = 1'b1;
            state_in = stat.walk_last ? S_OUT : S_WRD;
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/scba_dp.sv =====
// Datapath of the allocator: list heads, page table, link memory, divider and
// the result register. Depends on scba_pkg; driven by scba_ctrl commands.
module scba_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_type,
   input  logic [11:0]                    req_size,
   input  logic [31:0]                    free_address,
   input  logic [31:0]                    pool_base,
   input  logic [6:0]                     pages_en,
   input  scba_pkg::cmd_type              cmd,
   output scba_pkg::stat_type             stat,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [scba_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scba_pkg::*;

   logic                  type_ff, type_in;
   logic [11:0]           size_ff, size_in;
   logic [31:0]           off_ff, off_in;
   logic                  zero_ff, zero_in;
   logic [CLASS_W-1:0]    cls_ff, cls_in;
   ref_type               head_ff [CLASS_COUNT];
   ref_type               head_in [CLASS_COUNT];
   logic [NUM_PAGES-1:0]  busy_ff, busy_in;
   logic [SCAN_W-1:0]     scan_ff, scan_in;
   logic [PAGE_W-1:0]     cpg_ff, cpg_in;
   logic [IDX_W-1:0]      cidx_ff, cidx_in;
   logic [12:0]           rem_ff, rem_in;
   logic [11:0]           quo_ff, quo_in;
   logic [3:0]            dcnt_ff, dcnt_in;
   logic [USED_W-1:0]     used_ff, used_in;
   logic [ID_W-1:0]       cur_ff, cur_in;
   ref_type               kept_ff, kept_in;
   status_type            res_st_ff, res_st_in;
   logic [31:0]           res_ba_ff, res_ba_in;
   logic                  res_rel_ff, res_rel_in;
   logic [31:0]           res_rp_ff, res_rp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   link_type              link_mem [2**ID_W];
   link_type              link_rd_ff;
   logic                  link_we;
   logic [ID_W-1:0]       link_wa, link_ra;
   link_type              link_wd;

   page_info_type         page_mem [NUM_PAGES];
   page_info_type         page_rd_ff;
   logic                  page_we;
   logic [PAGE_W-1:0]     page_wa, page_ra;
   page_info_type         page_wd;

   ref_type               hd;
   logic [PAGE_W-1:0]     hp, fp, spg;
   logic [IDX_W-1:0]      hi, n_blk;
   logic [11:0]           inpg;
   logic                  in_range, early;
   status_type            early_st;
   logic                  scan_ok;
   logic [12:0]           div_t, div_d;
   logic                  div_ge;
   logic [ID_W-1:0]       fid;
   logic [31:0]           baddr, rpage;
   logic                  keep;

   function automatic logic [CLASS_W-1:0] class_of_size(input logic [11:0] s);
      logic [CLASS_W-1:0] c;
      c = CLASS_W'(CLASS_COUNT - 1);
      for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
         if (s <= (12'd8 << k)) c = CLASS_W'(k);
      end
      return c;
   endfunction

   assign hd = head_ff[cls_ff];
   assign hp = hd.id[IDX_W +: PAGE_W];
   assign hi = hd.id[IDX_W-1:0];
   assign fp = off_ff[PAGE_SHIFT +: PAGE_W];
   assign spg = scan_ff[PAGE_W-1:0];
   assign inpg = off_ff[PAGE_SHIFT-1:0];
   assign in_range = off_ff[31:PAGE_SHIFT] < (32 - PAGE_SHIFT)'(NUM_PAGES);
   assign n_blk = blocks_in_page(cls_ff);
   assign fid = {fp, quo_ff[IDX_W-1:0]};
   assign scan_ok = (32'(scan_ff) < 32'(pages_en)) && (32'(scan_ff) < 32'(NUM_PAGES));
   assign div_t = {rem_ff[11:0], quo_ff[11]};
   assign div_d = {1'b0, class_stride(cls_ff)};
   assign div_ge = div_t >= div_d;
   assign keep = cur_ff[IDX_W +: PAGE_W] != fp;
   assign baddr = pool_base + (32'(hp) << PAGE_SHIFT) + 32'(BLOCK_DATA_OFS)
                  + (32'(hi) << 2) + (32'(hi) << (cls_ff + 4'd3));
   assign rpage = pool_base + (32'(fp) << PAGE_SHIFT);

   // Requests that are settled without touching any list.
   always_comb begin
      early = 1'b0;
      early_st = ST_OK;
      if (type_ff == REQ_ALLOC) begin
         if (size_ff == 12'd0) begin
            early = 1'b1;
            early_st = ST_NULL;
         end else if (size_ff > 12'(MAX_CLASS_BYTES)) begin
            early = 1'b1;
            early_st = ST_TOO_LARGE;
         end
      end else if (zero_ff) begin
         early = 1'b1;
         early_st = ST_NULL;
      end else if (!in_range || !busy_ff[fp] || inpg < 12'(BLOCK_DATA_OFS)) begin
         early = 1'b1;
         early_st = ST_BAD_FREE;
      end
   end

   always_comb begin
      stat.is_alloc = type_ff == REQ_ALLOC;
      stat.early = early;
      stat.head_valid = hd.valid;
      stat.scan_hit = scan_ok && !busy_ff[spg];
      stat.scan_end = !scan_ok;
      stat.carve_last = cidx_ff == n_blk - 9'd1;
      stat.div_last = dcnt_ff == 4'(DIV_STEPS - 1);
      stat.geom_ok = (rem_ff == 13'd0) && (quo_ff < {3'd0, n_blk});
      stat.state_ok = !link_rd_ff.free && (used_ff != '0);
      stat.release_needed = used_ff == 9'd1;
      stat.walk_last = !link_rd_ff.next.valid;
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      case (cmd.link_sel)
         LRD_HEAD: link_ra = hd.id;
         LRD_FREE: link_ra = fid;
         LRD_CUR:  link_ra = cur_ff;
         default:  link_ra = hd.id;
      endcase
      page_ra = (type_ff == REQ_ALLOC) ? hp : fp;
   end

   always_comb begin
      type_in = type_ff;
      size_in = size_ff;
      off_in = off_ff;
      zero_in = zero_ff;
      cls_in = cls_ff;
      head_in = head_ff;
      busy_in = busy_ff;
      scan_in = scan_ff;
      cpg_in = cpg_ff;
      cidx_in = cidx_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      used_in = used_ff;
      cur_in = cur_ff;
      kept_in = kept_ff;
      res_st_in = res_st_ff;
      res_ba_in = res_ba_ff;
      res_rel_in = res_rel_ff;
      res_rp_in = res_rp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      link_we = 1'b0;
      link_wa = hd.id;
      link_wd = '0;
      page_we = 1'b0;
      page_wa = fp;
      page_wd = '0;

      if (cmd.load) begin
         type_in = req_type;
         size_in = req_size;
         off_in = free_address - pool_base;
         zero_in = free_address == 32'd0;
         cls_in = class_of_size(req_size);
         res_st_in = ST_OK;
         res_ba_in = 32'd0;
         res_rel_in = 1'b0;
         res_rp_in = 32'd0;
      end
      if (cmd.set_early) res_st_in = early_st;
      if (cmd.set_nopage) res_st_in = ST_NO_PAGE;
      if (cmd.set_bad) res_st_in = ST_BAD_FREE;

      // Pop the head block of the class list.
      if (cmd.pop) begin
         link_we = 1'b1;
         link_wa = hd.id;
         link_wd = '{free: 1'b0, next: link_rd_ff.next};
         head_in[cls_ff] = link_rd_ff.next;
         page_we = 1'b1;
         page_wa = hp;
         page_wd = '{cls: cls_ff, used: page_rd_ff.used + 9'd1};
         res_ba_in = baddr;
      end

      if (cmd.scan_start) scan_in = '0;
      if (cmd.scan_next) scan_in = scan_ff + SCAN_W'(1);

      if (cmd.carve_start) begin
         busy_in[spg] = 1'b1;
         cpg_in = spg;
         cidx_in = '0;
         page_we = 1'b1;
         page_wa = spg;
         page_wd = '{cls: cls_ff, used: '0};
      end
      if (cmd.carve_step) begin
         link_we = 1'b1;
         link_wa = {cpg_ff, cidx_ff};
         link_wd = '{free: 1'b1, next: hd};
         head_in[cls_ff] = '{valid: 1'b1, id: {cpg_ff, cidx_ff}};
         cidx_in = cidx_ff + 9'd1;
      end

      if (cmd.div_start) begin
         cls_in = page_rd_ff.cls;
         used_in = page_rd_ff.used;
         rem_in = '0;
         quo_in = inpg - 12'(BLOCK_DATA_OFS);
         dcnt_in = '0;
      end
      if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = div_t - div_d;
            quo_in = {quo_ff[10:0], 1'b1};
         end else begin
            rem_in = div_t;
            quo_in = {quo_ff[10:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 4'd1;
      end

      if (cmd.free_push) begin
         page_we = 1'b1;
         page_wa = fp;
         page_wd = '{cls: cls_ff, used: used_ff - 9'd1};
         link_we = 1'b1;
         link_wa = fid;
         link_wd = '{free: 1'b1, next: hd};
         head_in[cls_ff] = '{valid: 1'b1, id: fid};
         cur_in = fid;
         kept_in = '0;
      end

      // One list element per step: survivors are relinked in reverse order.
      if (cmd.walk_step) begin
         if (keep) begin
            link_we = 1'b1;
            link_wa = cur_ff;
            link_wd = '{free: 1'b1, next: kept_ff};
            kept_in = '{valid: 1'b1, id: cur_ff};
         end
         cur_in = link_rd_ff.next.id;
         if (!link_rd_ff.next.valid) begin
            head_in[cls_ff] = keep ? '{valid: 1'b1, id: cur_ff} : kept_ff;
            busy_in[fp] = 1'b0;
            res_rel_in = 1'b1;
            res_rp_in = rpage;
         end
      end

      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {4'd0, res_rp_ff, res_rel_ff, res_ba_ff, res_st_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int k = 0; k < CLASS_COUNT; k++) head_ff[k] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      size_ff <= size_in;
      off_ff <= off_in;
      zero_ff <= zero_in;
      cls_ff <= cls_in;
      scan_ff <= scan_in;
      cpg_ff <= cpg_in;
      cidx_ff <= cidx_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      used_ff <= used_in;
      cur_ff <= cur_in;
      kept_ff <= kept_in;
      res_st_ff <= res_st_in;
      res_ba_ff <= res_ba_in;
      res_rel_ff <= res_rel_in;
      res_rp_ff <= res_rp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (page_we) page_mem[page_wa] <= page_wd;
      page_rd_ff <= page_mem[page_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== src/size_class_block_allocator_core.sv =====
// Size-class block allocator: an allocate whose class list is not empty is decoded, pops
// the list head and loads the result; a free runs the 12-step divider that finds the block
// index. Carving a page scans the enabled pages (at most 64) for a free one, links each of
// its blocks into the class list and then decodes the request again. Releasing a page
// walks every listed block of that class, with a registered link read before each step.
// Reset clears the page-busy bits, list heads and result valid at once; no clearing pass.
// One item is in work at a time; a finished result may wait while the next is taken.
module size_class_block_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: req_size[11:0], free_address[43:12], zero fill to 48.
   input  logic [scba_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: req_type (0 allocate, 1 free).
   input  logic                            req_tuser,
   // Response stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: status[2:0], block_address[34:3], page_released[35],
   // released_page[67:36], zero fill to 72.
   output logic [scba_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [scba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import scba_pkg::*;

   // Register map: pool_base at byte 0 and pages_enabled at byte 4.
   logic [31:0] pool_base;
   logic [6:0]  pages_en;
   cmd_type     cmd;
   stat_type    stat;

   scba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .pool_base (pool_base),
      .pages_en  (pages_en)
   );

   // The controller sequences each request; it only takes a new transfer
   // when it is back in its idle state.
   scba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the list heads in flip-flops and the per-block links,
   // which also carry the free marks, in a memory addressed by {page, index}.
   // Entries of that memory are only read after they have been written by a
   // carve, so it needs no initialisation.
   scba_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_type     (req_tuser),
      .req_size     (req_tdata[11:0]),
      .free_address (req_tdata[43:12]),
      .pool_base    (pool_base),
      .pages_en     (pages_en),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata)
   );

   // A page is only reported as released on a successful free.
   a_release_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[2:0] == ST_OK)
      else $error("page released with a failing status");

   // Failing requests carry no addresses.
   a_fail_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |->
         rsp_tdata[34:3] == 32'd0 && rsp_tdata[67:35] == 33'd0)
      else $error("failing response carries an address");

   // After a request transfer the controller is not ready again in the cycle after it.
   a_one_in_work : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

endmodule

// ===== dv/size_class_block_allocator_core_tb.sv =====
// Self-checking bench for the size-class block allocator core: streams allocate and free
// requests, predicts every response and compares it field by field. Depends on scba_pkg.
`timescale 1ns / 1ps

module size_class_block_allocator_core_tb;
   import scba_pkg::*;

   localparam int TOTAL_BLOCKS = NUM_PAGES * MAX_BLOCKS_PER_PAGE;
   localparam int STALL_LIMIT = 200000;

   typedef struct {
      status_type  status;
      logic [31:0] block_address;
      logic        page_released;
      logic [31:0] released_page;
   } alloc_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   size_class_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the allocator state, updated as each request transfer is accepted.
   logic [31:0] shadow_base;
   logic [6:0]  shadow_pages_en;
   logic        page_busy_q [NUM_PAGES];
   int unsigned page_class_q [NUM_PAGES];
   int unsigned page_used_q [NUM_PAGES];
   int unsigned class_head [CLASS_COUNT];
   logic        class_head_ok [CLASS_COUNT];
   int unsigned block_next [TOTAL_BLOCKS];
   logic        block_next_ok [TOTAL_BLOCKS];
   logic        block_listed [TOTAL_BLOCKS];

   // Responses still owed by the block, oldest first.
   alloc_result_type pending_results[$];
   // Data addresses currently handed out, which the stimulus may free.
   logic [31:0] live_blocks[$];
   logic [31:0] last_alloc_addr;
   logic [31:0] last_freed_addr;

   int error_count;
   int alloc_count;
   int free_count;
   int release_count;
   int nopage_count;
   int idle_cycles;
   logic quiet;

   // ------------------------------------------------------------------
   // Clock, sink-side back-pressure and watchdog.
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int gap_length();
      if (quiet) return 0;
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, 2);
      return $urandom_range(5, 40);
   endfunction

   // The response side alternates bursts of readiness with stalls of random length.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = gap_length();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   // Page release walks a whole class list, so the limit allows for the longest walk.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Response checker: every response transfer is matched to the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[34:3] !== want.block_address) begin
               $error("block_address: expected %h, got %h", want.block_address,
                      rsp_tdata[34:3]);
               error_count++;
            end
            if (rsp_tdata[35] !== want.page_released) begin
               $error("page_released: expected %0d, got %0d", want.page_released,
                      rsp_tdata[35]);
               error_count++;
            end
            if (rsp_tdata[67:36] !== want.released_page) begin
               $error("released_page: expected %h, got %h", want.released_page,
                      rsp_tdata[67:36]);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Predictor.
   // ------------------------------------------------------------------
   function automatic int unsigned class_size(int unsigned c);
      return 8 << c;
   endfunction

   function automatic int unsigned page_capacity(int unsigned c);
      int unsigned n;
      n = 4084 / (4 + class_size(c));
      return (n > MAX_BLOCKS_PER_PAGE) ? MAX_BLOCKS_PER_PAGE : n;
   endfunction

   function automatic logic [31:0] page_base(int unsigned p);
      return shadow_base + 32'(p) * 32'd4096;
   endfunction

   function automatic void list_push(int unsigned c, int unsigned id);
      block_next[id] = class_head[c];
      block_next_ok[id] = class_head_ok[c];
      class_head[c] = id;
      class_head_ok[c] = 1'b1;
      block_listed[id] = 1'b1;
   endfunction

   // Takes the lowest free enabled page for class c and pushes its blocks in ascending index order.
   function automatic logic carve_for_class(int unsigned c);
      int unsigned lim;
      int unsigned p;
      lim = (shadow_pages_en > NUM_PAGES) ? NUM_PAGES : shadow_pages_en;
      for (p = 0; p < lim; p++)
         if (!page_busy_q[p]) break;
      if (p >= lim) return 1'b0;
      page_busy_q[p] = 1'b1;
      page_class_q[p] = c;
      page_used_q[p] = 0;
      for (int unsigned i = 0; i < page_capacity(c); i++)
         list_push(c, p * MAX_BLOCKS_PER_PAGE + i);
      return 1'b1;
   endfunction

   // Unlinks every block of page p; the blocks that stay end up in reversed order.
   function automatic void unlink_page(int unsigned c, int unsigned p);
      int unsigned cur;
      int unsigned kept;
      int unsigned nxt;
      logic cur_ok;
      logic kept_ok;
      logic nxt_ok;
      cur = class_head[c];
      cur_ok = class_head_ok[c];
      kept = 0;
      kept_ok = 1'b0;
      while (cur_ok) begin
         nxt = block_next[cur];
         nxt_ok = block_next_ok[cur];
         if (cur / MAX_BLOCKS_PER_PAGE != p) begin
            block_next[cur] = kept;
            block_next_ok[cur] = kept_ok;
            kept = cur;
            kept_ok = 1'b1;
         end else begin
            block_listed[cur] = 1'b0;
         end
         cur = nxt;
         cur_ok = nxt_ok;
      end
      class_head[c] = kept;
      class_head_ok[c] = kept_ok;
   endfunction

   function automatic alloc_result_type predict_response(logic kind, logic [11:0] size,
                                                         logic [31:0] addr);
      alloc_result_type r;
      int unsigned c;
      int unsigned id;
      int unsigned p;
      int unsigned stride;
      int unsigned ofs;
      logic [31:0] off;
      r.status = ST_OK;
      r.block_address = '0;
      r.page_released = 1'b0;
      r.released_page = '0;
      if (kind == REQ_ALLOC) begin
         if (size == 0) begin
            r.status = ST_NULL;
         end else if (size > MAX_CLASS_BYTES) begin
            r.status = ST_TOO_LARGE;
         end else begin
            c = 0;
            while (c + 1 < CLASS_COUNT && size > class_size(c)) c++;
            if (!class_head_ok[c] && !carve_for_class(c)) begin
               r.status = ST_NO_PAGE;
            end else begin
               id = class_head[c];
               class_head[c] = block_next[id];
               class_head_ok[c] = block_next_ok[id];
               block_listed[id] = 1'b0;
               p = id / MAX_BLOCKS_PER_PAGE;
               page_used_q[p] = (page_used_q[p] + 1) & 'h1FF;
               r.block_address = page_base(p) + 32'd16
                  + 32'((id % MAX_BLOCKS_PER_PAGE) * (4 + class_size(page_class_q[p])));
            end
         end
      end else if (addr == 0) begin
         r.status = ST_NULL;
      end else begin
         off = addr - shadow_base;
         p = off >> 12;
         r.status = ST_BAD_FREE;
         if (p < NUM_PAGES && page_busy_q[p] && off[11:0] >= 16) begin
            c = page_class_q[p] % CLASS_COUNT;
            stride = 4 + class_size(c);
            ofs = off[11:0] - 16;
            if (ofs % stride == 0 && ofs / stride < page_capacity(c)) begin
               id = p * MAX_BLOCKS_PER_PAGE + ofs / stride;
               if (!block_listed[id] && page_used_q[p] != 0) begin
                  r.status = ST_OK;
                  page_used_q[p] = page_used_q[p] - 1;
                  list_push(c, id);
                  if (page_used_q[p] == 0) begin
                     unlink_page(c, p);
                     page_busy_q[p] = 1'b0;
                     r.page_released = 1'b1;
                     r.released_page = page_base(p);
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Shared stimulus tasks.
   // ------------------------------------------------------------------
   // Sends one request, predicts its response at the accepting edge, then maybe idles.
   task automatic send_request(logic kind, logic [11:0] size, logic [31:0] addr);
      alloc_result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, addr, size};
      do @(posedge clock); while (!req_tready);
      r = predict_response(kind, size, addr);
      pending_results.push_back(r);
      if (kind == REQ_ALLOC && r.status == ST_OK) begin
         live_blocks.push_back(r.block_address);
         last_alloc_addr = r.block_address;
         alloc_count++;
      end
      if (kind == REQ_FREE && r.status == ST_OK) free_count++;
      if (r.page_released) release_count++;
      if (r.status == ST_NO_PAGE) nopage_count++;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic free_live(int idx);
      logic [31:0] a;
      a = live_blocks[idx];
      live_blocks.delete(idx);
      last_freed_addr = a;
      send_request(REQ_FREE, 12'($urandom), a);
   endtask

   task automatic free_everything();
      while (live_blocks.size() > 0)
         free_live($urandom_range(0, live_blocks.size() - 1));
   endtask

   // Waits until every response has been taken, plus a short tail for in-flight work.
   task automatic wait_idle();
      if (req_tvalid) begin
         @(posedge clock);
         req_tvalid <= 1'b0;
      end
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Writes one register and reads it back; only called while the block is idle.
   task automatic write_register(reg_index_type index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(index) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      if (index == REG_POOL_BASE) shadow_base = value;
      else shadow_pages_en = value[6:0];
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (index == REG_POOL_BASE && prdata !== shadow_base) begin
         $error("pool_base readback: expected %h, got %h", shadow_base, prdata);
         error_count++;
      end
      if (index == REG_PAGES_EN && prdata[6:0] !== shadow_pages_en) begin
         $error("pages_enabled readback: expected %h, got %h", shadow_pages_en, prdata[6:0]);
         error_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Test tasks.
   // ------------------------------------------------------------------
   // Field extremes, every class, and each error case of a free.
   task automatic test_directed();
      logic [31:0] big_block;
      send_request(REQ_ALLOC, 12'd0, '0);
      send_request(REQ_ALLOC, 12'd4095, '0);
      send_request(REQ_ALLOC, 12'd2049, '0);
      for (int c = 0; c < CLASS_COUNT; c++)
         send_request(REQ_ALLOC, 12'(8 << c), '0);
      big_block = last_alloc_addr;
      send_request(REQ_ALLOC, 12'd1, '0);
      send_request(REQ_ALLOC, 12'd1025, '0);
      send_request(REQ_FREE, 12'hFFF, 32'h0);
      send_request(REQ_FREE, '0, 32'hFFFF_FFF0);              // outside the pool
      send_request(REQ_FREE, '0, shadow_base + 32'h2_0010);   // page never carved
      send_request(REQ_FREE, '0, live_blocks[0] + 32'd4);     // not at a block's data start
      send_request(REQ_FREE, '0, shadow_base + 32'd4);        // inside the page header
      send_request(REQ_FREE, '0, big_block + 32'd2052);       // index past the page's blocks
      // A block freed twice: the second attempt is rejected while its page stays busy.
      free_live(0);
      send_request(REQ_FREE, '0, last_freed_addr);
      free_everything();
   endtask

   // A single enabled page, then none, then a value past the page count.
   task automatic test_page_limits();
      wait_idle();
      write_register(REG_PAGES_EN, 32'd1);
      send_request(REQ_ALLOC, 12'd2048, '0);
      send_request(REQ_ALLOC, 12'd1500, '0);
      send_request(REQ_ALLOC, 12'd8, '0);
      free_everything();
      wait_idle();
      write_register(REG_PAGES_EN, 32'd0);
      send_request(REQ_ALLOC, 12'd100, '0);
      wait_idle();
      write_register(REG_PAGES_EN, 32'h7F);
      send_request(REQ_ALLOC, 12'd100, '0);
      free_everything();
   endtask

   // Pool placed at the top of the address space so page addresses wrap, then at zero.
   task automatic test_base_extremes();
      wait_idle();
      write_register(REG_POOL_BASE, 32'hFFFF_F000);
      for (int i = 0; i < 4; i++) send_request(REQ_ALLOC, 12'(1 + 600 * i), '0);
      free_everything();
      wait_idle();
      write_register(REG_POOL_BASE, 32'h0);
      send_request(REQ_ALLOC, 12'd16, '0);
      send_request(REQ_FREE, '0, 32'hFFFF_FFFF);
      free_everything();
   endtask

   // Random mix weighted towards valid allocate and free pairs, with some noise.
   task automatic random_phase(int items, logic pause_midway);
      int pick;
      int c;
      logic [11:0] size;
      for (int n = 0; n < items; n++) begin
         if (pause_midway && n == items / 2) wait_idle();
         quiet = (n % 100) >= 80;
         pick = $urandom_range(0, 99);
         if (live_blocks.size() > 0 && (pick < 42 || live_blocks.size() > 150)) begin
            free_live($urandom_range(0, live_blocks.size() - 1));
         end else if (pick < 46) begin
            send_request(REQ_FREE, 12'($urandom), $urandom);
         end else if (pick < 48) begin
            send_request(REQ_FREE, 12'($urandom), last_freed_addr);
         end else if (pick < 50) begin
            send_request(REQ_FREE, 12'($urandom), 32'h0);
         end else if (pick < 53) begin
            send_request(REQ_FREE, 12'($urandom), shadow_base + $urandom_range(0, 'h40FFF));
         end else if (pick < 55) begin
            send_request(REQ_ALLOC, 12'($urandom_range(2049, 4095)), $urandom);
         end else if (pick < 57) begin
            send_request(REQ_ALLOC, 12'd0, $urandom);
         end else begin
            c = $urandom_range(0, CLASS_COUNT - 1);
            size = 12'($urandom_range((c == 0) ? 1 : (4 << c) + 1, 8 << c));
            send_request(REQ_ALLOC, size, $urandom);
         end
      end
      quiet = 1'b0;
      free_everything();
   endtask

   task automatic test_random();
      wait_idle();
      write_register(REG_POOL_BASE, $urandom & 32'hFFFF_F000);
      write_register(REG_PAGES_EN, 32'd4);
      random_phase(200, 1'b1);
      wait_idle();
      write_register(REG_POOL_BASE, POOL_BASE_RESET);
      write_register(REG_PAGES_EN, 32'd64);
      random_phase(220, 1'b0);
      wait_idle();
      write_register(REG_POOL_BASE, 32'h8000_0000);
      write_register(REG_PAGES_EN, 32'd2);
      random_phase(180, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Sequence.
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      quiet = 1'b0;
      error_count = 0;
      alloc_count = 0;
      free_count = 0;
      release_count = 0;
      nopage_count = 0;
      last_alloc_addr = '0;
      last_freed_addr = '0;
      shadow_base = POOL_BASE_RESET;
      shadow_pages_en = PAGES_EN_RESET;
      for (int p = 0; p < NUM_PAGES; p++) begin
         page_busy_q[p] = 1'b0;
         page_class_q[p] = 0;
         page_used_q[p] = 0;
      end
      for (int c = 0; c < CLASS_COUNT; c++) begin
         class_head[c] = 0;
         class_head_ok[c] = 1'b0;
      end
      for (int i = 0; i < TOTAL_BLOCKS; i++) begin
         block_next[i] = 0;
         block_next_ok[i] = 1'b0;
         block_listed[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_page_limits();
      test_base_extremes();
      test_random();
      wait_idle();
      repeat (50) @(posedge clock);

      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         error_count++;
      end
      $display("Covered %0d allocations, %0d frees and %0d page returns to the pool,",
               alloc_count, free_count, release_count);
      $display("with %0d allocations refused for lack of a page, across six pool settings.",
               nopage_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
